// ----- sv/bceo_pkg.sv -----
// Shared types, constants and codes for the button chord effect overlay controller.
package bceo_pkg;

	// Parameter defaults
	localparam int EFFECT_COUNT_DEF = 4;
	localparam int STEM_COUNT_DEF   = 4;

	// Fixed field widths
	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int TRACK_W   = 4;

	// Register reset values
	localparam logic [CFG_W-1:0] ARRIVAL_RST = 16'd120;
	localparam logic [CFG_W-1:0] RELEASE_RST = 16'd600;
	localparam logic [CFG_W-1:0] PAIRING_RST = 16'd2000;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ARRIVAL = 2'd0,
		REG_RELEASE = 2'd1,
		REG_PAIRING = 2'd2
	} cfg_reg_t;

	// Chord machine phases
	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_ONE_DOWN = 3'd1,
		PH_SINGLE   = 3'd2,
		PH_ARMED    = 3'd3,
		PH_WAIT     = 3'd4
	} phase_t;

	// Chord event codes
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_OPENED  = 3'd1,
		EV_CLOSED  = 3'd2,
		EV_AMBIG   = 3'd3,
		EV_PAIRING = 3'd4,
		EV_TARGET  = 3'd5
	} chord_evt_t;

	// Timing registers
	typedef struct packed {
		logic [CFG_W-1:0] arrival_window_ms;
		logic [CFG_W-1:0] release_limit_ms;
		logic [CFG_W-1:0] pairing_hold_ms;
	} cfg_t;

	// Input word: one button scan
	typedef struct packed {
		logic [TIME_W-1:0]  now_ms;
		logic               minus_level;
		logic               plus_level;
		logic               function_level;
		logic [TRACK_W-1:0] track_levels;
	} scan_t;

	// Output word
	typedef struct packed {
		logic [1:0]         volume_fire;
		logic [1:0]         volume_consumed;
		logic               fn_claim;
		logic [TRACK_W-1:0] trk_claim;
		logic [2:0]         chord_event;
		logic               overlay_open;
		logic               global_scope;
		logic [1:0]         stem_sel;
		logic [TRACK_W-1:0] mom_fx;
		logic [TRACK_W-1:0] lat_fx;
		logic [TRACK_W-1:0] on_fx;
	} result_t;

	// Chord unit status toward the top level
	typedef struct packed {
		logic [1:0] fire;
		logic [1:0] vol_cons;
		logic       fn_cons;
		chord_evt_t evt;
		logic       open;
		logic       scope;
	} chord_stat_t;

endpackage

// ----- sv/bceo_chord.sv -----
// Chord state machine, overlay open/scope state and target stem stepping.
module bceo_chord #(
	parameter int STEM_COUNT = bceo_pkg::STEM_COUNT_DEF,
	localparam int TGT_W = (STEM_COUNT > 1) ? $clog2(STEM_COUNT) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  bceo_pkg::cfg_t                  cfg,
	input  logic [bceo_pkg::TIME_W-1:0]     now_ms,
	input  logic                            m,
	input  logic                            p,
	input  logic                            fn,
	output bceo_pkg::chord_stat_t           stat,
	output logic [TGT_W-1:0]                target
);

	localparam logic [TGT_W-1:0] TGT_MAX = TGT_W'(STEM_COUNT - 1);

	bceo_pkg::phase_t              phase_q, phase_d;
	logic [bceo_pkg::TIME_W-1:0]   first_q, first_d;
	logic [bceo_pkg::TIME_W-1:0]   second_q, second_d;
	logic                          first_minus_q, first_minus_d;
	logic                          with_fn_q, with_fn_d;
	logic                          open_q, open_d;
	logic                          scope_q, scope_d;
	logic [TGT_W-1:0]              target_q, target_d;
	logic                          prev_m_q, prev_p_q;

	logic                          m_edge, p_edge, any, both;
	logic [bceo_pkg::TIME_W-1:0]   gap, overlap;
	logic                          in_window, pair_hit, quick;

	assign m_edge    = m & ~prev_m_q;
	assign p_edge    = p & ~prev_p_q;
	assign any       = m | p;
	assign both      = m & p;
	assign gap       = now_ms - first_q;
	assign overlap   = now_ms - second_q;
	assign in_window = gap <= bceo_pkg::TIME_W'(cfg.arrival_window_ms);
	assign pair_hit  = overlap >= bceo_pkg::TIME_W'(cfg.pairing_hold_ms);
	assign quick     = overlap < bceo_pkg::TIME_W'(cfg.release_limit_ms);

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= bceo_pkg::PH_IDLE;
			first_q       <= '0;
			second_q      <= '0;
			first_minus_q <= 1'b0;
			with_fn_q     <= 1'b0;
			open_q        <= 1'b0;
			scope_q       <= 1'b0;
			target_q      <= '0;
			prev_m_q      <= 1'b0;
			prev_p_q      <= 1'b0;
		end else if (en) begin
			phase_q       <= phase_d;
			first_q       <= first_d;
			second_q      <= second_d;
			first_minus_q <= first_minus_d;
			with_fn_q     <= with_fn_d;
			open_q        <= open_d;
			scope_q       <= scope_d;
			target_q      <= target_d;
			prev_m_q      <= m;
			prev_p_q      <= p;
		end
	end

	// Next state, claims and target stepping
	always_comb begin
		phase_d       = phase_q;
		first_d       = first_q;
		second_d      = second_q;
		first_minus_d = first_minus_q;
		with_fn_d     = with_fn_q;
		open_d        = open_q;
		scope_d       = scope_q;
		target_d      = target_q;
		stat          = '0;
		stat.evt      = bceo_pkg::EV_NONE;

		case (phase_q)
			bceo_pkg::PH_IDLE: begin
				if (both) begin
					first_d       = now_ms;
					second_d      = now_ms;
					first_minus_d = 1'b1;
					with_fn_d     = fn;
					phase_d       = bceo_pkg::PH_ARMED;
				end else if (m_edge || p_edge) begin
					first_d       = now_ms;
					first_minus_d = m_edge;
					with_fn_d     = fn;
					phase_d       = bceo_pkg::PH_ONE_DOWN;
				end
			end
			bceo_pkg::PH_ONE_DOWN: begin
				if (both) begin
					if (in_window) begin
						second_d = now_ms;
						phase_d  = bceo_pkg::PH_ARMED;
					end else begin
						phase_d  = bceo_pkg::PH_SINGLE;
					end
				end else if (!any) begin
					stat.fire = first_minus_q ? 2'b01 : 2'b10;
					phase_d   = bceo_pkg::PH_IDLE;
				end else if (!in_window) begin
					stat.fire = first_minus_q ? 2'b01 : 2'b10;
					phase_d   = bceo_pkg::PH_SINGLE;
				end
			end
			bceo_pkg::PH_SINGLE: begin
				stat.fire = {p_edge, m_edge};
				if (!any) begin
					phase_d = bceo_pkg::PH_IDLE;
				end
			end
			bceo_pkg::PH_ARMED: begin
				if (pair_hit) begin
					stat.evt = bceo_pkg::EV_PAIRING;
					phase_d  = bceo_pkg::PH_WAIT;
				end else if (!both) begin
					if (quick) begin
						if (open_q) begin
							open_d   = 1'b0;
							stat.evt = bceo_pkg::EV_CLOSED;
						end else begin
							open_d   = 1'b1;
							scope_d  = with_fn_q;
							stat.evt = bceo_pkg::EV_OPENED;
						end
					end else begin
						stat.evt = bceo_pkg::EV_AMBIG;
					end
					phase_d = bceo_pkg::PH_WAIT;
				end
			end
			bceo_pkg::PH_WAIT: begin
				if (!any) begin
					phase_d = bceo_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = bceo_pkg::PH_IDLE;
			end
		endcase

		// Claims follow the phase after this scan
		if (phase_d != bceo_pkg::PH_IDLE) begin
			stat.vol_cons = {p, m};
		end
		if ((phase_d == bceo_pkg::PH_ARMED || phase_d == bceo_pkg::PH_WAIT) && with_fn_d) begin
			stat.fn_cons = 1'b1;
		end

		// Function plus volume steps the stem in open stem scope
		if (open_d && !scope_d && fn && (stat.fire != 2'b00)) begin
			if (stat.fire[0]) begin
				target_d = (target_q == '0) ? TGT_MAX : target_q - TGT_W'(1);
			end else begin
				target_d = (target_q == TGT_MAX) ? '0 : target_q + TGT_W'(1);
			end
			stat.fire     = 2'b00;
			stat.vol_cons = {p, m};
			stat.fn_cons  = 1'b1;
			stat.evt      = bceo_pkg::EV_TARGET;
		end

		stat.open  = open_d;
		stat.scope = scope_d;
	end

	assign target = target_d;

endmodule

// ----- sv/bceo_effect.sv -----
// Effect bank: momentary and latch bits driven by track button edges.
module bceo_effect #(
	parameter int EFFECT_COUNT = bceo_pkg::EFFECT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          open,
	input  logic                          fn,
	input  logic [bceo_pkg::TRACK_W-1:0]  tracks,
	output logic [bceo_pkg::TRACK_W-1:0]  trk_claim,
	output logic                          fn_cons,
	output logic [bceo_pkg::TRACK_W-1:0]  mom_fx,
	output logic [bceo_pkg::TRACK_W-1:0]  lat_fx
);

	localparam int PAD_W = EFFECT_COUNT + bceo_pkg::TRACK_W;

	logic [bceo_pkg::TRACK_W-1:0] prev_q;
	logic [EFFECT_COUNT-1:0]      mom_q, mom_d;
	logic [EFFECT_COUNT-1:0]      lat_q, lat_d;
	logic [EFFECT_COUNT-1:0]      cons;
	logic [PAD_W-1:0]             trk_pad, prev_pad;
	logic [PAD_W-1:0]             cons_pad, mom_pad, lat_pad;
	logic [EFFECT_COUNT-1:0]      trk, prv;

	// Effects beyond the track field never see a press
	assign trk_pad = PAD_W'(tracks);
	assign prev_pad = PAD_W'(prev_q);
	assign trk = trk_pad[EFFECT_COUNT-1:0];
	assign prv = prev_pad[EFFECT_COUNT-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			mom_q  <= '0;
			lat_q  <= '0;
		end else if (en) begin
			prev_q <= tracks;
			mom_q  <= mom_d;
			lat_q  <= lat_d;
		end
	end

	// Per-effect edge handling; momentary bits drop while closed
	always_comb begin
		mom_d   = mom_q;
		lat_d   = lat_q;
		cons    = '0;
		fn_cons = 1'b0;
		if (!open) begin
			mom_d = '0;
		end else begin
			for (int e = 0; e < EFFECT_COUNT; e++) begin
				if (trk[e] && !prv[e]) begin
					if (fn) begin
						lat_d[e] = ~lat_q[e];
						fn_cons  = 1'b1;
					end else begin
						mom_d[e] = 1'b1;
					end
					cons[e] = 1'b1;
				end else if (!trk[e] && prv[e]) begin
					mom_d[e] = 1'b0;
					cons[e]  = 1'b1;
				end else if (trk[e]) begin
					cons[e] = 1'b1;
				end
			end
		end
	end

	assign cons_pad = PAD_W'(cons);
	assign mom_pad  = PAD_W'(mom_d);
	assign lat_pad  = PAD_W'(lat_d);
	assign trk_claim = cons_pad[bceo_pkg::TRACK_W-1:0];
	assign mom_fx    = mom_pad[bceo_pkg::TRACK_W-1:0];
	assign lat_fx    = lat_pad[bceo_pkg::TRACK_W-1:0];

endmodule

// ----- sv/button_chord_effect_overlay_control_unit.sv -----
// A scan accepted into the input register has its result word computed and
// registered in the result register, where the consumer takes it.
// Throughput: one scan per clock while result_ready holds; the input register and
// the result register let a new scan in while a finished result waits for the consumer.
// Reset: chord machine idle, overlay closed in stem scope, all effect bits and
// edge history cleared, timing registers back to 120, 600 and 2000 ms.
module button_chord_effect_overlay_control_unit #(
	parameter int EFFECT_COUNT = bceo_pkg::EFFECT_COUNT_DEF,
	parameter int STEM_COUNT   = bceo_pkg::STEM_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bceo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bceo_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            scan_valid,
	output logic                            scan_ready,
	input  bceo_pkg::scan_t                 scan,
	output logic                            result_valid,
	input  logic                            result_ready,
	output bceo_pkg::result_t               result
);

	localparam int TGT_W = (STEM_COUNT > 1) ? $clog2(STEM_COUNT) : 1;

	bceo_pkg::cfg_t        cfg_q;
	bceo_pkg::scan_t       scan_s1;
	logic                  valid_s1;
	bceo_pkg::result_t     result_s2;
	logic                  valid_s2;
	logic                  adv;
	bceo_pkg::chord_stat_t cstat;
	logic [TGT_W-1:0]      target;
	logic [TGT_W+1:0]      target_pad;
	logic [bceo_pkg::TRACK_W-1:0] trk_cons, mom, lat;
	logic                  fx_fn_cons;
	bceo_pkg::result_t     res_d;

	// Timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arrival_window_ms <= bceo_pkg::ARRIVAL_RST;
			cfg_q.release_limit_ms  <= bceo_pkg::RELEASE_RST;
			cfg_q.pairing_hold_ms   <= bceo_pkg::PAIRING_RST;
		end else if (cfg_we) begin
			case (bceo_pkg::cfg_reg_t'(cfg_index))
				bceo_pkg::REG_ARRIVAL: cfg_q.arrival_window_ms <= cfg_data;
				bceo_pkg::REG_RELEASE: cfg_q.release_limit_ms  <= cfg_data;
				bceo_pkg::REG_PAIRING: cfg_q.pairing_hold_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the stage advances when the result register is free or drains
	assign adv        = valid_s1 & (~valid_s2 | result_ready);
	assign scan_ready = ~valid_s1 | adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan_ready) begin
			valid_s1 <= scan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_valid && scan_ready) begin
			scan_s1 <= scan;
		end
	end

	bceo_chord #(
		.STEM_COUNT (STEM_COUNT)
	) u_chord (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.cfg    (cfg_q),
		.now_ms (scan_s1.now_ms),
		.m      (scan_s1.minus_level),
		.p      (scan_s1.plus_level),
		.fn     (scan_s1.function_level),
		.stat   (cstat),
		.target (target)
	);

	bceo_effect #(
		.EFFECT_COUNT (EFFECT_COUNT)
	) u_effect (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.open      (cstat.open),
		.fn        (scan_s1.function_level),
		.tracks    (scan_s1.track_levels),
		.trk_claim (trk_cons),
		.fn_cons   (fx_fn_cons),
		.mom_fx    (mom),
		.lat_fx    (lat)
	);

	// Result word assembly
	assign target_pad = (TGT_W + 2)'(target);

	always_comb begin
		res_d              = '0;
		res_d.volume_fire     = cstat.fire;
		res_d.volume_consumed = cstat.vol_cons;
		res_d.fn_claim        = cstat.fn_cons | fx_fn_cons;
		res_d.trk_claim       = trk_cons;
		res_d.chord_event     = cstat.evt;
		res_d.overlay_open    = cstat.open;
		res_d.global_scope    = cstat.scope;
		res_d.stem_sel        = target_pad[1:0];
		res_d.mom_fx          = mom;
		res_d.lat_fx          = lat;
		res_d.on_fx           = mom | lat;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= res_d;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

// ----- sim/tb_button_chord_effect_overlay_control_unit.sv -----
// Testbench for the button chord effect overlay controller: directed and random scans, self-checking.
module tb_button_chord_effect_overlay_control_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int EFFECTS     = bceo_pkg::EFFECT_COUNT_DEF;
	localparam int STEMS       = bceo_pkg::STEM_COUNT_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 68;
	localparam int SETTLE_CYC  = 6;

	// Index past the last register; writes to it must be ignored
	localparam logic [bceo_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [bceo_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bceo_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                           scan_valid = 1'b0;
	logic                           scan_ready;
	bceo_pkg::scan_t                scan_word = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	bceo_pkg::result_t              result_word;

	// Stimulus and expected result words
	bceo_pkg::scan_t   scan_backlog[$];
	bceo_pkg::result_t overlay_results_q[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int stall_cycles = 0;

	// Generator state
	logic [31:0] gen_ms = '0;
	logic [3:0]  gen_trk = '0;

	// Predictor copy of the timing registers and controller state
	bceo_pkg::cfg_t   model_cfg;
	bceo_pkg::phase_t chord_ph;
	logic [31:0]      t_first, t_second;
	logic             first_minus, chord_fn_held;
	logic             ov_open, ov_global;
	int               target_idx;
	logic [3:0]       mom_bits, lat_bits, prev_trk;
	logic             prev_m, prev_p;

	button_chord_effect_overlay_control_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.scan_valid   (scan_valid),
		.scan_ready   (scan_ready),
		.scan         (scan_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_word)
	);

	always #5 clk = ~clk;

	// Expected result word for one scan; advances the predictor state
	function automatic bceo_pkg::result_t scan_to_overlay(bceo_pkg::scan_t s);
		bceo_pkg::result_t    r;
		logic [31:0]          gap;
		logic                 m, p, fn, m_edge, p_edge, any_dn, both_dn;
		logic                 fire_m, fire_p, cons_m, cons_p, cons_f;
		logic                 now_dn, was_dn;
		logic [3:0]           cons_t, bitm;
		bceo_pkg::chord_evt_t ev;

		m       = s.minus_level;
		p       = s.plus_level;
		fn      = s.function_level;
		m_edge  = m && !prev_m;
		p_edge  = p && !prev_p;
		any_dn  = m || p;
		both_dn = m && p;
		fire_m  = 1'b0;
		fire_p  = 1'b0;
		cons_m  = 1'b0;
		cons_p  = 1'b0;
		cons_f  = 1'b0;
		cons_t  = '0;
		ev      = bceo_pkg::EV_NONE;

		// chord machine
		case (chord_ph)
			bceo_pkg::PH_IDLE: begin
				if (both_dn) begin
					t_first       = s.now_ms;
					t_second      = s.now_ms;
					first_minus   = 1'b1;
					chord_fn_held = fn;
					chord_ph      = bceo_pkg::PH_ARMED;
				end else if (m_edge || p_edge) begin
					t_first       = s.now_ms;
					first_minus   = m_edge;
					chord_fn_held = fn;
					chord_ph      = bceo_pkg::PH_ONE_DOWN;
				end
			end
			bceo_pkg::PH_ONE_DOWN: begin
				gap = s.now_ms - t_first;
				if (both_dn) begin
					if (gap <= 32'(model_cfg.arrival_window_ms)) begin
						t_second = s.now_ms;
						chord_ph = bceo_pkg::PH_ARMED;
					end else begin
						chord_ph = bceo_pkg::PH_SINGLE;
					end
				end else if (!any_dn) begin
					if (first_minus) fire_m = 1'b1; else fire_p = 1'b1;
					chord_ph = bceo_pkg::PH_IDLE;
				end else if (gap > 32'(model_cfg.arrival_window_ms)) begin
					if (first_minus) fire_m = 1'b1; else fire_p = 1'b1;
					chord_ph = bceo_pkg::PH_SINGLE;
				end
			end
			bceo_pkg::PH_SINGLE: begin
				if (m_edge) fire_m = 1'b1;
				if (p_edge) fire_p = 1'b1;
				if (!any_dn) chord_ph = bceo_pkg::PH_IDLE;
			end
			bceo_pkg::PH_ARMED: begin
				gap = s.now_ms - t_second;
				if (gap >= 32'(model_cfg.pairing_hold_ms)) begin
					ev       = bceo_pkg::EV_PAIRING;
					chord_ph = bceo_pkg::PH_WAIT;
				end else if (!both_dn) begin
					if (gap < 32'(model_cfg.release_limit_ms)) begin
						if (ov_open) begin
							ov_open = 1'b0;
							ev      = bceo_pkg::EV_CLOSED;
						end else begin
							ov_open   = 1'b1;
							ov_global = chord_fn_held;
							ev        = bceo_pkg::EV_OPENED;
						end
					end else begin
						ev = bceo_pkg::EV_AMBIG;
					end
					chord_ph = bceo_pkg::PH_WAIT;
				end
			end
			bceo_pkg::PH_WAIT: begin
				if (!any_dn) chord_ph = bceo_pkg::PH_IDLE;
			end
			default: chord_ph = bceo_pkg::PH_IDLE;
		endcase

		if (chord_ph != bceo_pkg::PH_IDLE) begin
			cons_m = m;
			cons_p = p;
		end
		if ((chord_ph == bceo_pkg::PH_ARMED || chord_ph == bceo_pkg::PH_WAIT) && chord_fn_held)
			cons_f = 1'b1;

		// target stepping in stem scope
		if (ov_open && !ov_global && fn && (fire_m || fire_p)) begin
			if (fire_m)
				target_idx = (target_idx + STEMS - 1) % STEMS;
			else
				target_idx = (target_idx + 1) % STEMS;
			fire_m = 1'b0;
			fire_p = 1'b0;
			cons_m = m;
			cons_p = p;
			cons_f = 1'b1;
			ev     = bceo_pkg::EV_TARGET;
		end

		// effect bank
		if (!ov_open) begin
			mom_bits = '0;
		end else begin
			for (int e = 0; e < EFFECTS && e < bceo_pkg::TRACK_W; e++) begin
				bitm   = 4'(1) << e;
				now_dn = s.track_levels[e];
				was_dn = prev_trk[e];
				if (now_dn && !was_dn) begin
					if (fn) begin
						lat_bits = lat_bits ^ bitm;
						cons_f   = 1'b1;
					end else begin
						mom_bits = mom_bits | bitm;
					end
					cons_t = cons_t | bitm;
				end else if (!now_dn && was_dn) begin
					mom_bits = mom_bits & ~bitm;
					cons_t   = cons_t | bitm;
				end else if (now_dn) begin
					cons_t = cons_t | bitm;
				end
			end
		end

		r.volume_fire     = {fire_p, fire_m};
		r.volume_consumed = {cons_p, cons_m};
		r.fn_claim        = cons_f;
		r.trk_claim       = cons_t;
		r.chord_event     = ev;
		r.overlay_open    = ov_open;
		r.global_scope    = ov_global;
		r.stem_sel        = 2'(target_idx);
		r.mom_fx          = mom_bits;
		r.lat_fx          = lat_bits;
		r.on_fx           = mom_bits | lat_bits;

		prev_m   = m;
		prev_p   = p;
		prev_trk = s.track_levels;
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [7:0] exp_v, act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", fname, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// Scan driver: presents backlog words, predicts each accepted one
	always @(posedge clk or negedge arst_n) begin : scan_drv
		bceo_pkg::scan_t nxt;
		if (!arst_n) begin
			scan_valid <= 1'b0;
		end else begin
			if (scan_valid && scan_ready)
				overlay_results_q.push_back(scan_to_overlay(scan_word));
			if (!scan_valid || scan_ready) begin
				if (scan_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = scan_backlog.pop_front();
					scan_word  <= nxt;
					scan_valid <= 1'b1;
				end else begin
					scan_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random backpressure
	always @(posedge clk or negedge arst_n) begin : result_mon
		bceo_pkg::result_t exp_r;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (overlay_results_q.size() == 0) begin
					$error("result word with no scan outstanding");
					mismatch_count++;
				end else begin
					exp_r = overlay_results_q.pop_front();
					check_field("volume_fire", 8'(exp_r.volume_fire),
						8'(result_word.volume_fire));
					check_field("volume_consumed", 8'(exp_r.volume_consumed),
						8'(result_word.volume_consumed));
					check_field("fn_claim", 8'(exp_r.fn_claim), 8'(result_word.fn_claim));
					check_field("trk_claim", 8'(exp_r.trk_claim), 8'(result_word.trk_claim));
					check_field("chord_event", 8'(exp_r.chord_event),
						8'(result_word.chord_event));
					check_field("overlay_open", 8'(exp_r.overlay_open),
						8'(result_word.overlay_open));
					check_field("global_scope", 8'(exp_r.global_scope),
						8'(result_word.global_scope));
					check_field("stem_sel", 8'(exp_r.stem_sel), 8'(result_word.stem_sel));
					check_field("mom_fx", 8'(exp_r.mom_fx), 8'(result_word.mom_fx));
					check_field("lat_fx", 8'(exp_r.lat_fx), 8'(result_word.lat_fx));
					check_field("on_fx", 8'(exp_r.on_fx), 8'(result_word.on_fx));
				end
			end
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: too long without any word moving
	always @(posedge clk) begin
		if ((scan_valid && scan_ready) || (result_valid && result_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("** button_chord_effect_overlay_control_unit: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(input logic [bceo_pkg::CFG_IDX_W-1:0] idx,
		input logic [bceo_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			bceo_pkg::REG_ARRIVAL: model_cfg.arrival_window_ms = val;
			bceo_pkg::REG_RELEASE: model_cfg.release_limit_ms  = val;
			bceo_pkg::REG_PAIRING: model_cfg.pairing_hold_ms   = val;
			default: ;
		endcase
	endtask

	task automatic set_timing(input logic [bceo_pkg::CFG_W-1:0] arr, rel, pair);
		write_reg(bceo_pkg::REG_ARRIVAL, arr);
		write_reg(bceo_pkg::REG_RELEASE, rel);
		write_reg(bceo_pkg::REG_PAIRING, pair);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every scan is sent and every result word has come back
	task automatic wait_drain();
		do
			@(posedge clk);
		while (scan_backlog.size() > 0 || scan_valid || overlay_results_q.size() > 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic add_scan(input logic [31:0] t, input logic m, p, f, input logic [3:0] trk);
		bceo_pkg::scan_t s;
		s.now_ms         = t;
		s.minus_level    = m;
		s.plus_level     = p;
		s.function_level = f;
		s.track_levels   = trk;
		scan_backlog.push_back(s);
	endtask

	// Random-walk tracks, advance time by dt
	task automatic add_rand(input logic m, p, f, input logic [31:0] dt);
		gen_ms = gen_ms + dt;
		if ($urandom_range(2) == 0)
			gen_trk = 4'($urandom_range(15));
		add_scan(gen_ms, m, p, f, gen_trk);
	endtask

	// Time step around a threshold: just below, at, just above, or anywhere
	function automatic logic [31:0] pick_gap(input logic [31:0] bound);
		case ($urandom_range(4))
			0: return (bound == 0) ? 32'd0 : bound - 1;
			1: return bound;
			2: return bound + 1;
			3: return $urandom_range(0, 2 * bound + 4);
			default: return $urandom_range(0, 20);
		endcase
	endfunction

	// One random button gesture
	task automatic add_sequence();
		int          kind, hold_n, n;
		logic        fn_l, first_m;
		logic [31:0] t2, total, bound;

		kind    = $urandom_range(9);
		fn_l    = ($urandom_range(9) < 3);
		first_m = 1'($urandom_range(1));
		case (kind)
			// chord, released early, late or after a long hold
			0, 1, 2: begin
				if ($urandom_range(2) == 0) begin
					add_rand(1'b1, 1'b1, fn_l, pick_gap(20));
				end else begin
					add_rand(first_m, !first_m, fn_l, pick_gap(20));
					add_rand(1'b1, 1'b1, fn_l, pick_gap(32'(model_cfg.arrival_window_ms)));
				end
				bound  = ($urandom_range(2) == 0) ? 32'(model_cfg.pairing_hold_ms)
					: 32'(model_cfg.release_limit_ms);
				total  = pick_gap(bound);
				t2     = gen_ms;
				hold_n = $urandom_range(0, 2);
				for (int k = 1; k <= hold_n; k++) begin
					gen_ms = t2 + total * k / (hold_n + 1);
					add_rand(1'b1, 1'b1, fn_l, 0);
				end
				gen_ms = t2 + total;
				if ($urandom_range(1)) begin
					add_rand(first_m, !first_m, fn_l, 0);
					add_rand(1'b0, 1'b0, fn_l, pick_gap(20));
				end else begin
					add_rand(1'b0, 1'b0, fn_l, 0);
				end
			end
			// function held with a volume tap: stem step when open
			3, 4: begin
				add_rand(first_m, !first_m, 1'b1, pick_gap(20));
				add_rand(1'b0, 1'b0, 1'b1, pick_gap(32'(model_cfg.arrival_window_ms)));
				add_rand(1'b0, 1'b0, 1'($urandom_range(1)), pick_gap(20));
			end
			// lone press held past the window, then the other volume
			5: begin
				add_rand(first_m, !first_m, fn_l, pick_gap(20));
				add_rand(first_m, !first_m, fn_l, pick_gap(32'(model_cfg.arrival_window_ms)));
				add_rand(1'b1, 1'b1, fn_l, pick_gap(32'(model_cfg.arrival_window_ms)));
				add_rand(1'b0, 1'b0, fn_l, pick_gap(20));
			end
			// track play
			6, 7: begin
				n = $urandom_range(2, 5);
				for (int k = 0; k < n; k++)
					add_rand(1'b0, 1'b0, 1'($urandom_range(1)), pick_gap(20));
			end
			// plain volume tap
			8: begin
				add_rand(first_m, !first_m, 1'b0, pick_gap(20));
				add_rand(1'b0, 1'b0, 1'b0, pick_gap(32'(model_cfg.arrival_window_ms)));
			end
			// noise with arbitrary time jumps
			default: begin
				n = $urandom_range(1, 3);
				for (int k = 0; k < n; k++)
					add_rand(1'($urandom_range(1)), 1'($urandom_range(1)),
						1'($urandom_range(1)), $urandom());
			end
		endcase
	endtask

	initial begin
		model_cfg     = '{bceo_pkg::ARRIVAL_RST, bceo_pkg::RELEASE_RST, bceo_pkg::PAIRING_RST};
		chord_ph      = bceo_pkg::PH_IDLE;
		t_first       = '0;
		t_second      = '0;
		first_minus   = 1'b0;
		chord_fn_held = 1'b0;
		ov_open       = 1'b0;
		ov_global     = 1'b0;
		target_idx    = 0;
		mom_bits      = '0;
		lat_bits      = '0;
		prev_trk      = '0;
		prev_m        = 1'b0;
		prev_p        = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Out-of-range register index must leave the timing untouched
		write_reg(REG_UNUSED, 16'($urandom_range(65535)));
		@(posedge clk);
		cfg_we <= 1'b0;

		// Directed pass at reset timing
		send_idle_pct  = 14;
		recv_stall_pct = 76;
		add_scan(32'd100, 1, 1, 0, 4'h0);          // both volumes in one scan
		add_scan(32'd150, 0, 0, 0, 4'h0);          // quick release opens, stem scope
		add_scan(32'd200, 1, 0, 1, 4'h0);
		add_scan(32'd250, 0, 0, 1, 4'h0);          // step target down, wraps to top
		add_scan(32'd300, 0, 1, 1, 4'h0);
		add_scan(32'd310, 0, 0, 1, 4'h0);          // step target up, wraps to zero
		add_scan(32'd320, 0, 0, 0, 4'hF);          // momentary on all tracks
		add_scan(32'd330, 0, 0, 0, 4'h0);
		add_scan(32'd340, 0, 0, 1, 4'hF);          // latch toggle on all tracks
		add_scan(32'd350, 0, 0, 0, 4'h5);
		add_scan(32'd360, 0, 0, 1, 4'h0);
		add_scan(32'hFFFF_FFF0, 1, 0, 0, 4'h0);    // chord across time wrap
		add_scan(32'h0000_0010, 1, 1, 0, 4'h0);
		add_scan(32'h0000_0810, 1, 1, 0, 4'h0);    // held past pairing hold
		add_scan(32'h0000_0820, 0, 0, 0, 4'h0);
		add_scan(32'h0000_1000, 1, 1, 1, 4'h0);
		add_scan(32'h0000_1258, 0, 0, 0, 4'h0);    // release exactly at limit: ambiguous
		add_scan(32'h0000_2000, 1, 1, 0, 4'hA);
		add_scan(32'h0000_2257, 0, 0, 0, 4'hA);    // just under limit: closes
		add_scan(32'h0000_3000, 0, 1, 1, 4'h0);
		add_scan(32'h0000_3078, 1, 1, 1, 4'h0);    // second press right at the window
		add_scan(32'h0000_3082, 0, 0, 1, 4'h0);    // opens in global scope
		add_scan(32'h0000_4000, 1, 0, 0, 4'h0);
		add_scan(32'h0000_4079, 1, 0, 0, 4'h0);    // window passed: fires, single press
		add_scan(32'h0000_4082, 1, 1, 0, 4'h0);    // plus edge fires too
		add_scan(32'h0000_408C, 0, 0, 0, 4'h0);
		gen_ms = 32'h0000_5000;
		wait_drain();

		// Random phases over several timing settings
		for (int ph_i = 0; ph_i < 6; ph_i++) begin
			if (ph_i < 2) begin
				send_idle_pct  = 14;
				recv_stall_pct = 76;
			end else if (ph_i < 4) begin
				send_idle_pct  = 76;
				recv_stall_pct = 14;
			end else begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			case (ph_i)
				0: set_timing(bceo_pkg::ARRIVAL_RST, bceo_pkg::RELEASE_RST,
					bceo_pkg::PAIRING_RST);
				1: set_timing(16'd0, 16'd0, 16'd0);
				2: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: set_timing(16'($urandom_range(1, 200)), 16'($urandom_range(1, 800)),
					16'($urandom_range(801, 3000)));
				4: set_timing(16'd30, 16'd2000, 16'd500);
				default: set_timing(16'($urandom_range(65535)), 16'($urandom_range(65535)),
					16'($urandom_range(65535)));
			endcase
			while (scan_backlog.size() < PHASE_ITEMS)
				add_sequence();
			wait_drain();
		end

		if (mismatch_count == 0)
			$display("** button_chord_effect_overlay_control_unit: PASSED **");
		else
			$display("** button_chord_effect_overlay_control_unit: FAILED **");
		$finish;
	end

endmodule
